// File: rtl/core/clwc_pkg.sv
// clwc_pkg: shared constants, operation codes and controller/datapath structs
// for the circular list with cursor; no dependencies

package clwc_pkg;

  localparam int CAPACITY = 16;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int LEN_W    = $clog2(CAPACITY + 1);

  localparam int KIND_W   = 2;
  localparam int KEY_W    = 32;
  localparam int YEAR_W   = 16;
  localparam int POS_W    = 4;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 5;
  localparam int ENTRY_W  = KEY_W + YEAR_W;

  // operation kinds
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NEXT   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_PREV   = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

  // datapath commands
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP        = 4'd0;
  localparam logic [OP_W-1:0] OP_LATCH      = 4'd1;
  localparam logic [OP_W-1:0] OP_SET_STATUS = 4'd2;
  localparam logic [OP_W-1:0] OP_APPEND1    = 4'd3;
  localparam logic [OP_W-1:0] OP_APPEND2    = 4'd4;
  localparam logic [OP_W-1:0] OP_DEL_START  = 4'd5;
  localparam logic [OP_W-1:0] OP_DEL_WALK   = 4'd6;
  localparam logic [OP_W-1:0] OP_DEL_LINKS  = 4'd7;
  localparam logic [OP_W-1:0] OP_STEP_START = 4'd8;
  localparam logic [OP_W-1:0] OP_STEP_WAIT  = 4'd9;
  localparam logic [OP_W-1:0] OP_LOAD_OUT   = 4'd10;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [STAT_W-1:0] stat;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              len_zero;
    logic              full;
    logic              pos_bad;
    logic              pos_zero;
    logic              cnt_one;
    logic              cur_valid;
  } flags_t;

endpackage

// File: rtl/core/clwc_in_if.sv
// clwc_in_if: input channel of the circular list, valid/ready with payload
// depends on clwc_pkg

interface clwc_in_if;
  logic                        valid;
  logic                        ready;
  logic [clwc_pkg::KIND_W-1:0] kind;
  logic [clwc_pkg::KEY_W-1:0]  song_key;
  logic [clwc_pkg::YEAR_W-1:0] song_year;
  logic [clwc_pkg::POS_W-1:0]  position;

  modport source (output valid, kind, song_key, song_year, position, input ready);
  modport sink   (input valid, kind, song_key, song_year, position, output ready);
endinterface

// File: rtl/core/clwc_out_if.sv
// clwc_out_if: result channel of the circular list, valid/ready with payload
// depends on clwc_pkg

interface clwc_out_if;
  logic                         valid;
  logic                         ready;
  logic [clwc_pkg::STAT_W-1:0]  status;
  logic                         has_current;
  logic [clwc_pkg::KEY_W-1:0]   current_key;
  logic [clwc_pkg::YEAR_W-1:0]  current_year;
  logic [clwc_pkg::COUNT_W-1:0] entry_count;

  modport source (output valid, status, has_current, current_key, current_year,
                  entry_count, input ready);
  modport sink   (input valid, status, has_current, current_key, current_year,
                  entry_count, output ready);
endinterface

// File: rtl/core/clwc_ram.sv
// clwc_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module clwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/core/clwc_ctrl.sv
// clwc_ctrl: sequencer of the circular list, drives datapath commands and handshakes
// depends on clwc_pkg

module clwc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  clwc_pkg::flags_t flags,
  output clwc_pkg::cmd_t   cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DISPATCH  = 3'd1;
  localparam logic [2:0] S_APPEND2   = 3'd2;
  localparam logic [2:0] S_DEL_WALK  = 3'd3;
  localparam logic [2:0] S_DEL_LINKS = 3'd4;
  localparam logic [2:0] S_STEP_WAIT = 3'd5;
  localparam logic [2:0] S_RESULT    = 3'd6;
  localparam logic [2:0] S_OUT       = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = clwc_pkg::OP_NOP;
    cmd.stat      = clwc_pkg::STAT_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = clwc_pkg::OP_LATCH;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (flags.kind)
          clwc_pkg::KIND_APPEND: begin
            if (flags.full) begin
              cmd.op    = clwc_pkg::OP_SET_STATUS;
              cmd.stat  = clwc_pkg::STAT_FULL;
              state_nxt = S_RESULT;
            end else begin
              cmd.op    = clwc_pkg::OP_APPEND1;
              state_nxt = flags.len_zero ? S_RESULT : S_APPEND2;
            end
          end
          clwc_pkg::KIND_DELETE: begin
            priority if (flags.len_zero) begin
              cmd.op    = clwc_pkg::OP_SET_STATUS;
              cmd.stat  = clwc_pkg::STAT_EMPTY;
              state_nxt = S_RESULT;
            end else if (flags.pos_bad) begin
              cmd.op    = clwc_pkg::OP_SET_STATUS;
              cmd.stat  = clwc_pkg::STAT_BADPOS;
              state_nxt = S_RESULT;
            end else begin
              cmd.op    = clwc_pkg::OP_DEL_START;
              state_nxt = flags.pos_zero ? S_DEL_LINKS : S_DEL_WALK;
            end
          end
          default: begin
            if (flags.len_zero) begin
              cmd.op    = clwc_pkg::OP_SET_STATUS;
              cmd.stat  = clwc_pkg::STAT_EMPTY;
              state_nxt = S_RESULT;
            end else begin
              cmd.op    = clwc_pkg::OP_STEP_START;
              state_nxt = flags.cur_valid ? S_STEP_WAIT : S_RESULT;
            end
          end
        endcase
      end
      S_APPEND2: begin
        cmd.op    = clwc_pkg::OP_APPEND2;
        state_nxt = S_RESULT;
      end
      S_DEL_WALK: begin
        cmd.op = clwc_pkg::OP_DEL_WALK;
        if (flags.cnt_one) begin
          state_nxt = S_DEL_LINKS;
        end
      end
      S_DEL_LINKS: begin
        cmd.op    = clwc_pkg::OP_DEL_LINKS;
        state_nxt = S_RESULT;
      end
      S_STEP_WAIT: begin
        cmd.op    = clwc_pkg::OP_STEP_WAIT;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        // entry read under the cursor in flight
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = clwc_pkg::OP_LOAD_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/core/clwc_dpath.sv
// clwc_dpath: list registers, slot and link rams and result registers
// depends on clwc_pkg and clwc_ram

module clwc_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  clwc_pkg::cmd_t                cmd,
  output clwc_pkg::flags_t              flags,
  input  logic [clwc_pkg::KIND_W-1:0]   in_kind,
  input  logic [clwc_pkg::KEY_W-1:0]    in_song_key,
  input  logic [clwc_pkg::YEAR_W-1:0]   in_song_year,
  input  logic [clwc_pkg::POS_W-1:0]    in_position,
  output logic [clwc_pkg::STAT_W-1:0]   out_status,
  output logic                          out_has_current,
  output logic [clwc_pkg::KEY_W-1:0]    out_current_key,
  output logic [clwc_pkg::YEAR_W-1:0]   out_current_year,
  output logic [clwc_pkg::COUNT_W-1:0]  out_entry_count
);

  localparam int SW = clwc_pkg::SLOT_W;
  localparam int LW = clwc_pkg::LEN_W;

  // list control state
  logic [clwc_pkg::CAPACITY-1:0] in_use_r, in_use_nxt;
  logic [SW-1:0] head_r, head_nxt, tail_r, tail_nxt, cur_r, cur_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          cur_valid_r, cur_valid_nxt;

  // working registers
  logic [clwc_pkg::KIND_W-1:0] kind_r;
  logic [clwc_pkg::KEY_W-1:0]  key_r;
  logic [clwc_pkg::YEAR_W-1:0] year_r;
  logic [clwc_pkg::POS_W-1:0]  pos_r, cnt_r, cnt_nxt;
  logic [SW-1:0]               walk_r, walk_nxt, free_r, free_nxt;
  logic [clwc_pkg::STAT_W-1:0] stat_r, stat_nxt;

  // result registers
  logic [clwc_pkg::STAT_W-1:0]  out_status_r;
  logic                         out_has_r;
  logic [clwc_pkg::KEY_W-1:0]   out_key_r;
  logic [clwc_pkg::YEAR_W-1:0]  out_year_r;
  logic [clwc_pkg::COUNT_W-1:0] out_count_r;

  // ram ports
  logic                         ent_we;
  logic [SW-1:0]                ent_waddr;
  logic [clwc_pkg::ENTRY_W-1:0] ent_wdata, ent_rdata;
  logic                         fwd_we, bwd_we;
  logic [SW-1:0]                fwd_waddr, fwd_wdata, bwd_waddr, bwd_wdata;
  logic [SW-1:0]                link_raddr, fwd_rdata, bwd_rdata;

  logic [SW-1:0] free_slot;
  logic          go_next;

  clwc_ram #(.WIDTH(clwc_pkg::ENTRY_W), .DEPTH(clwc_pkg::CAPACITY)) u_entry_ram (
    .clk     (clk),
    .we      (ent_we),
    .wr_addr (ent_waddr),
    .wr_data (ent_wdata),
    .rd_addr (cur_r),
    .rd_data (ent_rdata)
  );

  clwc_ram #(.WIDTH(SW), .DEPTH(clwc_pkg::CAPACITY)) u_fwd_ram (
    .clk     (clk),
    .we      (fwd_we),
    .wr_addr (fwd_waddr),
    .wr_data (fwd_wdata),
    .rd_addr (link_raddr),
    .rd_data (fwd_rdata)
  );

  clwc_ram #(.WIDTH(SW), .DEPTH(clwc_pkg::CAPACITY)) u_bwd_ram (
    .clk     (clk),
    .we      (bwd_we),
    .wr_addr (bwd_waddr),
    .wr_data (bwd_wdata),
    .rd_addr (link_raddr),
    .rd_data (bwd_rdata)
  );

  // lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = clwc_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_slot = SW'(i);
      end
    end
  end

  assign go_next = (kind_r == clwc_pkg::KIND_NEXT);

  assign flags.kind      = kind_r;
  assign flags.len_zero  = (len_r == '0);
  assign flags.full      = (len_r == LW'(clwc_pkg::CAPACITY));
  assign flags.pos_bad   = (32'(pos_r) >= 32'(len_r));
  assign flags.pos_zero  = (pos_r == '0);
  assign flags.cnt_one   = (cnt_r == clwc_pkg::POS_W'(1));
  assign flags.cur_valid = cur_valid_r;

  always_comb begin
    in_use_nxt    = in_use_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    walk_nxt      = walk_r;
    free_nxt      = free_r;
    stat_nxt      = stat_r;
    ent_we        = 1'b0;
    ent_waddr     = free_slot;
    ent_wdata     = {key_r, year_r};
    fwd_we        = 1'b0;
    fwd_waddr     = free_slot;
    fwd_wdata     = free_slot;
    bwd_we        = 1'b0;
    bwd_waddr     = free_slot;
    bwd_wdata     = free_slot;
    link_raddr    = walk_r;
    unique case (cmd.op)
      clwc_pkg::OP_SET_STATUS: begin
        stat_nxt = cmd.stat;
      end
      clwc_pkg::OP_APPEND1: begin
        stat_nxt             = cmd.stat;
        free_nxt             = free_slot;
        ent_we               = 1'b1;
        fwd_we               = 1'b1;
        bwd_we               = 1'b1;
        in_use_nxt[free_slot] = 1'b1;
        len_nxt              = len_r + LW'(1);
        if (len_r == '0) begin
          head_nxt = free_slot;
          tail_nxt = free_slot;
        end else begin
          fwd_wdata = head_r;
          bwd_wdata = tail_r;
        end
      end
      clwc_pkg::OP_APPEND2: begin
        fwd_we    = 1'b1;
        fwd_waddr = tail_r;
        fwd_wdata = free_r;
        bwd_we    = 1'b1;
        bwd_waddr = head_r;
        bwd_wdata = free_r;
        tail_nxt  = free_r;
      end
      clwc_pkg::OP_DEL_START: begin
        stat_nxt   = cmd.stat;
        walk_nxt   = head_r;
        cnt_nxt    = pos_r;
        link_raddr = head_r;
      end
      clwc_pkg::OP_DEL_WALK: begin
        walk_nxt   = fwd_rdata;
        cnt_nxt    = cnt_r - clwc_pkg::POS_W'(1);
        link_raddr = fwd_rdata;
      end
      clwc_pkg::OP_DEL_LINKS: begin
        in_use_nxt[walk_r] = 1'b0;
        len_nxt            = len_r - LW'(1);
        if (len_r == LW'(1)) begin
          head_nxt      = '0;
          tail_nxt      = '0;
          cur_nxt       = '0;
          cur_valid_nxt = 1'b0;
        end else begin
          fwd_we    = 1'b1;
          fwd_waddr = bwd_rdata;
          fwd_wdata = fwd_rdata;
          bwd_we    = 1'b1;
          bwd_waddr = fwd_rdata;
          bwd_wdata = bwd_rdata;
          if (cur_valid_r && (cur_r == walk_r)) begin
            cur_nxt = fwd_rdata;
          end
          if (head_r == walk_r) begin
            head_nxt = fwd_rdata;
          end
          if (tail_r == walk_r) begin
            tail_nxt = bwd_rdata;
          end
        end
      end
      clwc_pkg::OP_STEP_START: begin
        stat_nxt   = cmd.stat;
        link_raddr = cur_r;
        if (!cur_valid_r) begin
          cur_nxt       = go_next ? head_r : tail_r;
          cur_valid_nxt = 1'b1;
        end
      end
      clwc_pkg::OP_STEP_WAIT: begin
        cur_nxt = go_next ? fwd_rdata : bwd_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r    <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      cur_r       <= '0;
      cur_valid_r <= 1'b0;
      len_r       <= '0;
    end else begin
      in_use_r    <= in_use_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cur_r       <= cur_nxt;
      cur_valid_r <= cur_valid_nxt;
      len_r       <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    walk_r <= walk_nxt;
    free_r <= free_nxt;
    stat_r <= stat_nxt;
    if (cmd.op == clwc_pkg::OP_LATCH) begin
      kind_r <= in_kind;
      key_r  <= in_song_key;
      year_r <= in_song_year;
      pos_r  <= in_position;
    end
    if (cmd.op == clwc_pkg::OP_LOAD_OUT) begin
      out_status_r <= stat_r;
      out_has_r    <= cur_valid_r;
      out_key_r    <= cur_valid_r ? ent_rdata[clwc_pkg::ENTRY_W-1:clwc_pkg::YEAR_W] : '0;
      out_year_r   <= cur_valid_r ? ent_rdata[clwc_pkg::YEAR_W-1:0] : '0;
      out_count_r  <= clwc_pkg::COUNT_W'(len_r);
    end
  end

  assign out_status       = out_status_r;
  assign out_has_current  = out_has_r;
  assign out_current_key  = out_key_r;
  assign out_current_year = out_year_r;
  assign out_entry_count  = out_count_r;

endmodule

// File: rtl/core/circular_list_with_cursor.sv
// circular_list_with_cursor: top level of the circular list with play cursor
// depends on clwc_pkg, clwc_in_if, clwc_out_if, clwc_ctrl and clwc_dpath
// after input transfer a rejected item, an append to an empty list or a step placing
// the cursor goes dispatch, result, out; other appends and steps add append2 or step
// wait, a delete walks to its position and relinks; one item at a time, the next taken
// the cycle after its result is loaded; sync reset empties the list, no clearing pass

module circular_list_with_cursor (
  input  logic       clk,
  input  logic       rst_n,
  clwc_in_if.sink    in_chan,
  clwc_out_if.source out_chan
);

  clwc_pkg::cmd_t   cmd;
  clwc_pkg::flags_t flags;

  clwc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .flags     (flags),
    .cmd       (cmd)
  );

  clwc_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .flags            (flags),
    .in_kind          (in_chan.kind),
    .in_song_key      (in_chan.song_key),
    .in_song_year     (in_chan.song_year),
    .in_position      (in_chan.position),
    .out_status       (out_chan.status),
    .out_has_current  (out_chan.has_current),
    .out_current_key  (out_chan.current_key),
    .out_current_year (out_chan.current_year),
    .out_entry_count  (out_chan.entry_count)
  );

endmodule

// File: tb/clwc_checker.sv
`timescale 1ns / 1ps
// clwc_checker: watches both channels of the circular list, keeps its own copy
// of the slots, links and cursor, and compares every result transfer in order
// depends on clwc_pkg, clwc_in_if and clwc_out_if

module clwc_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  clwc_in_if                        in_mon,
  clwc_out_if                       out_mon,
  output int unsigned               fail_count,
  output int unsigned               pending_results,
  output int unsigned               results_checked,
  output int unsigned               full_seen,
  output int unsigned               empty_seen,
  output int unsigned               badpos_seen,
  output logic [clwc_pkg::LEN_W-1:0] list_len
);
  import clwc_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               has_current;
    logic [KEY_W-1:0]   current_key;
    logic [YEAR_W-1:0]  current_year;
    logic [COUNT_W-1:0] entry_count;
  } cursor_view_t;

  logic [KEY_W-1:0]  slot_key  [CAPACITY];
  logic [YEAR_W-1:0] slot_year [CAPACITY];
  logic [SLOT_W-1:0] next_slot [CAPACITY];
  logic [SLOT_W-1:0] prev_slot [CAPACITY];
  logic [CAPACITY-1:0] slot_busy;
  logic [SLOT_W-1:0] head, tail, cursor;
  logic              cursor_on;
  logic [LEN_W-1:0]  entries;

  cursor_view_t expected_views [$];
  int unsigned fails, checked, n_full, n_empty, n_badpos;

  function automatic void clear_list();
    int s;
    for (s = 0; s < CAPACITY; s++) begin
      slot_key[s]  = '0;
      slot_year[s] = '0;
      next_slot[s] = '0;
      prev_slot[s] = '0;
    end
    slot_busy = '0;
    head      = '0;
    tail      = '0;
    cursor    = '0;
    cursor_on = 1'b0;
    entries   = '0;
  endfunction

  // applies one operation to the list copy and returns the view after it
  function automatic cursor_view_t apply_op(input logic [KIND_W-1:0] kind,
                                            input logic [KEY_W-1:0]  key,
                                            input logic [YEAR_W-1:0] year,
                                            input logic [POS_W-1:0]  pos);
    cursor_view_t      r;
    logic [SLOT_W-1:0] t, nx, pv, free_s;
    logic              found;
    int                s;
    r.status = STAT_OK;
    case (kind)
      KIND_APPEND: begin
        found  = 1'b0;
        free_s = '0;
        // lowest free slot wins
        for (s = CAPACITY - 1; s >= 0; s--) begin
          if (!slot_busy[s]) begin
            free_s = SLOT_W'(s);
            found  = 1'b1;
          end
        end
        if (entries >= CAPACITY || !found) begin
          r.status = STAT_FULL;
        end else begin
          slot_busy[free_s] = 1'b1;
          slot_key[free_s]  = key;
          slot_year[free_s] = year;
          if (entries == 0) begin
            head = free_s;
            tail = free_s;
          end else begin
            next_slot[tail]   = free_s;
            prev_slot[free_s] = tail;
            tail              = free_s;
          end
          next_slot[tail] = head;
          prev_slot[head] = tail;
          entries = entries + 1'b1;
        end
      end
      KIND_DELETE: begin
        if (entries == 0) begin
          r.status = STAT_EMPTY;
        end else if (pos >= entries) begin
          r.status = STAT_BADPOS;
        end else begin
          t = head;
          for (s = 0; s < pos; s++) t = next_slot[t];
          nx = next_slot[t];
          pv = prev_slot[t];
          if (cursor_on && cursor == t) cursor = nx;
          if (entries == 1) begin
            head      = '0;
            tail      = '0;
            cursor    = '0;
            cursor_on = 1'b0;
          end else begin
            next_slot[pv] = nx;
            prev_slot[nx] = pv;
            if (t == head) head = nx;
            if (t == tail) tail = pv;
          end
          slot_busy[t] = 1'b0;
          entries = entries - 1'b1;
        end
      end
      KIND_NEXT, KIND_PREV: begin
        if (entries == 0) begin
          r.status = STAT_EMPTY;
        end else if (!cursor_on) begin
          cursor    = (kind == KIND_NEXT) ? head : tail;
          cursor_on = 1'b1;
        end else begin
          cursor = (kind == KIND_NEXT) ? next_slot[cursor] : prev_slot[cursor];
        end
      end
      default: ;
    endcase
    r.has_current  = cursor_on;
    r.current_key  = cursor_on ? slot_key[cursor]  : '0;
    r.current_year = cursor_on ? slot_year[cursor] : '0;
    r.entry_count  = COUNT_W'(entries);
    return r;
  endfunction

  task automatic check_field(input string what, input logic [KEY_W-1:0] want,
                             input logic [KEY_W-1:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t mismatch %s: expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    cursor_view_t want;
    if (!rst_n) begin
      clear_list();
      expected_views.delete();
    end else begin
      // result side first so a result never matches the item taken this edge
      if (out_mon.valid && out_mon.ready) begin
        if (expected_views.size() == 0) begin
          fails++;
          $display("%0t unexpected result: expected none, actual status %0d key %0h",
                   $time, out_mon.status, out_mon.current_key);
        end else begin
          want = expected_views.pop_front();
          checked++;
          check_field("status", KEY_W'(want.status), KEY_W'(out_mon.status));
          check_field("has_current", KEY_W'(want.has_current),
                      KEY_W'(out_mon.has_current));
          check_field("current_key", want.current_key, out_mon.current_key);
          check_field("current_year", KEY_W'(want.current_year),
                      KEY_W'(out_mon.current_year));
          check_field("entry_count", KEY_W'(want.entry_count),
                      KEY_W'(out_mon.entry_count));
          if (want.status == STAT_FULL) n_full++;
          if (want.status == STAT_EMPTY) n_empty++;
          if (want.status == STAT_BADPOS) n_badpos++;
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_views.push_back(apply_op(in_mon.kind, in_mon.song_key,
                                          in_mon.song_year, in_mon.position));
      end
    end
    fail_count      <= fails;
    pending_results <= expected_views.size();
    results_checked <= checked;
    full_seen       <= n_full;
    empty_seen      <= n_empty;
    badpos_seen     <= n_badpos;
    list_len        <= entries;
  end

endmodule

// File: tb/circular_list_with_cursor_tb.sv
`timescale 1ns / 1ps
// circular_list_with_cursor_tb: directed and random list operations under
// several idling patterns; checking is done by clwc_checker
// depends on clwc_pkg, clwc_in_if, clwc_out_if, clwc_checker and the block

module circular_list_with_cursor_tb;
  import clwc_pkg::*;

  logic clk;
  logic rst_n;

  int unsigned fail_count, pending_results, results_checked;
  int unsigned full_seen, empty_seen, badpos_seen;
  logic [LEN_W-1:0] list_len;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req       = 0;
  int unsigned hold_ack, hold_left;

  clwc_in_if  in_chan ();
  clwc_out_if out_chan ();

  circular_list_with_cursor dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  clwc_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_chan),
    .out_mon         (out_chan),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .results_checked (results_checked),
    .full_seen       (full_seen),
    .empty_seen      (empty_seen),
    .badpos_seen     (badpos_seen),
    .list_len        (list_len)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // result side: random stalls, plus a long hold when one is requested
  initial begin
    out_chan.ready <= 1'b0;
    hold_ack  = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = 300;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(1, 100) > recv_stall_pct);
      end
    end
  end

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                           input logic [YEAR_W-1:0] year, input logic [POS_W-1:0] pos);
    while ($urandom_range(1, 100) <= send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.kind      <= kind;
    in_chan.song_key  <= key;
    in_chan.song_year <= year;
    in_chan.position  <= pos;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic run_random(input int unsigned count, input int unsigned idle_pct,
                            input int unsigned stall_pct, input bit long_hold);
    int unsigned       n, append_wt, r;
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    send_idle_pct   = idle_pct;
    recv_stall_pct <= stall_pct;
    append_wt       = 50;
    for (n = 0; n < count; n++) begin
      // bursts that grow, churn or shrink the list
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       append_wt = 85;
          1:       append_wt = 50;
          default: append_wt = 15;
        endcase
      end
      if (long_hold && n == count / 2) hold_req <= hold_req + 1;
      r = $urandom_range(1, 100);
      if (r <= append_wt) begin
        kind = KIND_APPEND;
      end else begin
        r = $urandom_range(0, 99);
        kind = (r < 50) ? KIND_DELETE : (r < 75) ? KIND_NEXT : KIND_PREV;
      end
      if (list_len == 0 || $urandom_range(0, 5) == 0) pos = POS_W'($urandom_range(0, 15));
      else pos = POS_W'($urandom_range(0, list_len - 1));
      send_item(kind, $urandom, YEAR_W'($urandom_range(0, 65535)), pos);
    end
  endtask

  initial begin
    int unsigned i;
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.kind      <= KIND_APPEND;
    in_chan.song_key  <= '0;
    in_chan.song_year <= '0;
    in_chan.position  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // empty list: steps and delete report empty
    send_item(KIND_NEXT, '0, '0, '0);
    send_item(KIND_PREV, '0, '0, '0);
    send_item(KIND_DELETE, '0, '0, '0);
    // fill to capacity, with extreme keys and years first
    for (i = 0; i < CAPACITY; i++) begin
      send_item(KIND_APPEND, (i == 0) ? '0 : (i == 1) ? '1 : $urandom,
                (i == 0) ? 16'h0000 : (i == 1) ? 16'hffff
                                                : YEAR_W'($urandom_range(0, 65535)),
                '0);
    end
    send_item(KIND_APPEND, 32'h5a5a_a5a5, 16'h1234, '0);
    // no cursor: prev lands on the tail
    send_item(KIND_PREV, '0, '0, '0);
    // delete the cursor entry at the tail, cursor wraps to the head
    send_item(KIND_DELETE, '0, '0, 4'd15);
    send_item(KIND_DELETE, '0, '0, 4'd15);
    send_item(KIND_DELETE, '0, '0, 4'd0);
    send_item(KIND_NEXT, '0, '0, '0);
    drain();

    run_random(400, 0, 0, 1'b1);
    drain();
    run_random(400, 51, 0, 1'b0);
    drain();
    run_random(400, 0, 51, 1'b0);
    drain();
    run_random(350, 23, 23, 1'b0);
    drain();
    repeat (40) @(posedge clk);

    $display("summary: %0d results checked over four idling phases and a long result hold",
             results_checked);
    $display("summary: full %0d, empty %0d, bad position %0d",
             full_seen, empty_seen, badpos_seen);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
